[sv/tts_pkg.sv]
// Shared types, constants and helpers of the tridiagonal solver.
`timescale 1ns / 1ps
package tts_pkg;
	localparam int MAX_ROWS  = 64;
	localparam int FRAC_BITS = 16;
	localparam int IDX_W     = $clog2(MAX_ROWS);
	localparam int CNT_W     = IDX_W + 1;
	localparam int ROW_W     = 6;
	localparam int PROD_W    = 64;
	localparam int WIDE_W    = 66;
	localparam int DIV_W     = 32 + FRAC_BITS;
	localparam int DIV_CNT_W = $clog2(DIV_W + 1);

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_ZERO = 2'd1;
	localparam logic [1:0] STAT_OVER = 2'd2;

	typedef struct packed {
		logic signed [31:0] sub_diag;
		logic signed [31:0] main_diag;
		logic signed [31:0] super_diag;
		logic signed [31:0] rhs_value;
		logic               last_row;
	} in_beat_t;

	typedef struct packed {
		logic signed [31:0] solution;
		logic [ROW_W-1:0]   row_index;
		logic               last_result;
		logic [1:0]         status;
	} out_beat_t;

	typedef enum logic [1:0] {
		KIND_FIRST,
		KIND_NEXT,
		KIND_OVER
	} row_kind_t;

	typedef struct packed {
		in_beat_t         row;
		row_kind_t        kind;
		logic [IDX_W-1:0] idx;
	} job_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_A,
		ST_MUL_B,
		ST_MUL_C,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_BS_RD,
		ST_BS_MUL,
		ST_BS_SUB,
		ST_EM_RD,
		ST_EM_LD,
		ST_EM_HOLD
	} back_state_t;

	// Clamp a wide signed value to 32 bits
	function automatic logic signed [31:0] sat_q(input logic signed [WIDE_W-1:0] v);
		logic signed [31:0] r;
		if (&v[WIDE_W-1:31] || ~|v[WIDE_W-1:31])
			r = v[31:0];
		else if (v[WIDE_W-1])
			r = {1'b1, {31{1'b0}}};
		else
			r = {1'b0, {31{1'b1}}};
		return r;
	endfunction
endpackage

[sv/tts_front.sv]
// Front end: row intake, row numbering and overflow marking, job queue.
`timescale 1ns / 1ps
module tts_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  tts_pkg::in_beat_t in_beat,
	output logic              job_valid,
	output tts_pkg::job_t     job,
	input  logic              job_pop
);
	import tts_pkg::*;

	logic [CNT_W-1:0] cnt_q;
	job_t             q_mem [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       fill_q;
	logic             push;
	job_t             new_job;

	assign in_stall  = (fill_q == 2'd2);
	assign push      = in_valid && !in_stall;
	assign job_valid = (fill_q != 2'd0);
	assign job       = q_mem[rd_ptr_q];

	// Classify the incoming row from the running row count
	always_comb begin
		new_job.row = in_beat;
		if (cnt_q == CNT_W'(MAX_ROWS)) begin
			new_job.kind = KIND_OVER;
			new_job.idx  = '0;
		end else begin
			new_job.kind = (cnt_q == '0) ? KIND_FIRST : KIND_NEXT;
			new_job.idx  = cnt_q[IDX_W-1:0];
		end
	end

	// Advance the row count; a last row closes the run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (push) begin
			if (in_beat.last_row)
				cnt_q <= '0;
			else if (cnt_q != CNT_W'(MAX_ROWS))
				cnt_q <= cnt_q + 1'b1;
		end
	end

	// Hold queue entries
	always_ff @(posedge clk) begin
		if (push)
			q_mem[wr_ptr_q] <= new_job;
	end

	// Move queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (job_pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !job_pop)
				fill_q <= fill_q + 2'd1;
			else if (job_pop && !push)
				fill_q <= fill_q - 2'd1;
		end
	end
endmodule

[sv/tts_div.sv]
// Restoring divider, one quotient bit per cycle: (num * 2^F) / den, saturated.
`timescale 1ns / 1ps
module tts_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] num,
	input  logic signed [31:0] den,
	output logic               done,
	output logic signed [31:0] quot
);
	import tts_pkg::*;

	logic [DIV_W-1:0]     dvd_q;
	logic [DIV_W-1:0]     quo_q;
	logic [31:0]          dvs_q;
	logic [32:0]          rem_q;
	logic                 neg_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [32:0]          rem_sh;
	logic                 fits;
	logic [31:0]          num_mag;
	logic [31:0]          den_mag;

	assign num_mag = num[31] ? 32'(-num) : 32'(num);
	assign den_mag = den[31] ? 32'(-den) : 32'(den);
	assign rem_sh  = {rem_q[31:0], dvd_q[DIV_W-1]};
	assign fits    = rem_sh >= {1'b0, dvs_q};
	assign done    = done_q;

	// Sign and clamp the magnitude quotient
	always_comb begin
		if (!neg_q) begin
			if (|quo_q[DIV_W-1:31])
				quot = {1'b0, {31{1'b1}}};
			else
				quot = quo_q[31:0];
		end else begin
			if (|quo_q[DIV_W-1:32] || (quo_q[31] && |quo_q[30:0]))
				quot = {1'b1, {31{1'b0}}};
			else
				quot = ~quo_q[31:0] + 32'd1;
		end
	end

	// Iterate one bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Shift dividend, remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {num_mag, {FRAC_BITS{1'b0}}};
			dvs_q <= den_mag;
			rem_q <= '0;
			quo_q <= '0;
			neg_q <= num[31] ^ den[31];
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIV_W-2:0], 1'b0};
			quo_q <= {quo_q[DIV_W-2:0], fits};
			rem_q <= fits ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
		end
	end
endmodule

[sv/tts_back.sv]
// Back end: forward elimination, stores, back substitution and result register.
`timescale 1ns / 1ps
module tts_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sym_mode,
	input  logic               job_valid,
	input  tts_pkg::job_t      job,
	output logic               job_pop,
	output logic               div_start,
	output logic signed [31:0] div_num_a,
	output logic signed [31:0] div_num_b,
	output logic signed [31:0] div_den,
	input  logic               div_done,
	input  logic signed [31:0] div_quot_a,
	input  logic signed [31:0] div_quot_b,
	output logic               out_valid,
	input  logic               out_stall,
	output tts_pkg::out_beat_t out_beat
);
	import tts_pkg::*;

	back_state_t               state_q;
	back_state_t               state_d;
	job_t                      job_q;
	logic signed [31:0]        prev_cp_q;
	logic signed [31:0]        prev_dp_q;
	logic signed [31:0]        prev_sup_q;
	logic [1:0]                err_q;
	logic signed [PROD_W-1:0]  p_s1;
	logic signed [31:0]        den_q;
	logic signed [31:0]        num_q;
	logic [CNT_W-1:0]          n_q;
	logic [IDX_W-1:0]          i_q;
	logic signed [31:0]        x_q;
	logic                      first_q;
	logic signed [31:0]        cp_rd_q;
	logic signed [31:0]        dp_rd_q;
	logic signed [31:0]        xm_rd_q;
	out_beat_t                 out_q;
	logic                      out_valid_q;
	logic signed [31:0]        cp_mem [MAX_ROWS];
	logic signed [31:0]        dp_mem [MAX_ROWS];
	logic signed [31:0]        x_mem  [MAX_ROWS];
	logic signed [31:0]        a_sel;
	logic                      zero_piv;
	logic signed [31:0]        cp_new;
	logic signed [31:0]        dp_new;
	logic signed [31:0]        x_new;
	logic                      row_wr;
	logic                      x_wr;
	logic                      em_last;

	assign out_valid = out_valid_q;
	assign out_beat  = out_q;
	assign div_num_a = job_q.row.super_diag;
	assign div_num_b = num_q;
	assign div_den   = den_q;
	assign zero_piv  = (den_q == '0);
	assign cp_new    = (job_q.row.last_row || zero_piv) ? '0 : div_quot_a;
	assign dp_new    = zero_piv ? '0 : div_quot_b;
	assign em_last   = (CNT_W'(i_q) + 1'b1) == n_q;
	assign x_new     = first_q ? dp_rd_q
		: sat_q(WIDE_W'(dp_rd_q) - WIDE_W'(p_s1 >>> FRAC_BITS));

	// Pick the sub-diagonal for this row
	always_comb begin
		if (job_q.kind == KIND_FIRST)
			a_sel = '0;
		else if (sym_mode)
			a_sel = prev_sup_q;
		else
			a_sel = job_q.row.sub_diag;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (job_valid) begin
					if (job.kind != KIND_OVER)
						state_d = ST_MUL_A;
					else if (job.row.last_row)
						state_d = ST_BS_RD;
				end
			end
			ST_MUL_A:    state_d = ST_MUL_B;
			ST_MUL_B:    state_d = ST_MUL_C;
			ST_MUL_C:    state_d = ST_DIV_GO;
			ST_DIV_GO:   state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (div_done)
					state_d = job_q.row.last_row ? ST_BS_RD : ST_IDLE;
			end
			ST_BS_RD:    state_d = ST_BS_MUL;
			ST_BS_MUL:   state_d = ST_BS_SUB;
			ST_BS_SUB:   state_d = (i_q == '0) ? ST_EM_RD : ST_BS_RD;
			ST_EM_RD:    state_d = ST_EM_LD;
			ST_EM_LD:    state_d = ST_EM_HOLD;
			ST_EM_HOLD: begin
				if (!out_stall)
					state_d = em_last ? ST_IDLE : ST_EM_RD;
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	// Control outputs
	always_comb begin
		job_pop   = 1'b0;
		div_start = 1'b0;
		row_wr    = 1'b0;
		x_wr      = 1'b0;
		case (state_q)
			ST_IDLE:     job_pop   = job_valid;
			ST_DIV_GO:   div_start = 1'b1;
			ST_DIV_WAIT: row_wr    = div_done;
			ST_BS_SUB:   x_wr      = 1'b1;
			default:     job_pop   = 1'b0;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// Write and read the row stores
	always_ff @(posedge clk) begin
		if (row_wr) begin
			cp_mem[job_q.idx] <= cp_new;
			dp_mem[job_q.idx] <= dp_new;
		end
		if (x_wr)
			x_mem[i_q] <= x_new;
		cp_rd_q <= cp_mem[i_q];
		dp_rd_q <= dp_mem[i_q];
		xm_rd_q <= x_mem[i_q];
	end

	// Run control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_cp_q   <= '0;
			prev_dp_q   <= '0;
			prev_sup_q  <= '0;
			err_q       <= STAT_OK;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (job_valid && job.kind == KIND_OVER)
						err_q <= STAT_OVER;
				end
				ST_DIV_WAIT: begin
					if (div_done) begin
						prev_cp_q  <= cp_new;
						prev_dp_q  <= dp_new;
						prev_sup_q <= job_q.row.super_diag;
						if (zero_piv && err_q == STAT_OK)
							err_q <= STAT_ZERO;
					end
				end
				ST_EM_LD: out_valid_q <= 1'b1;
				ST_EM_HOLD: begin
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						if (em_last) begin
							prev_cp_q  <= '0;
							prev_dp_q  <= '0;
							prev_sup_q <= '0;
							err_q      <= STAT_OK;
						end
					end
				end
				default: out_valid_q <= out_valid_q;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				job_q   <= job;
				first_q <= 1'b1;
				n_q     <= CNT_W'(MAX_ROWS);
				i_q     <= IDX_W'(MAX_ROWS - 1);
			end
			ST_MUL_A: p_s1 <= a_sel * prev_cp_q;
			ST_MUL_B: begin
				den_q <= sat_q(WIDE_W'(job_q.row.main_diag) - WIDE_W'(p_s1 >>> FRAC_BITS));
				p_s1  <= a_sel * prev_dp_q;
			end
			ST_MUL_C:
				num_q <= sat_q(WIDE_W'(job_q.row.rhs_value) - WIDE_W'(p_s1 >>> FRAC_BITS));
			ST_DIV_WAIT: begin
				n_q <= CNT_W'(job_q.idx) + 1'b1;
				i_q <= job_q.idx;
			end
			ST_BS_MUL: p_s1 <= cp_rd_q * x_q;
			ST_BS_SUB: begin
				x_q     <= x_new;
				first_q <= 1'b0;
				if (i_q != '0)
					i_q <= i_q - 1'b1;
			end
			ST_EM_LD: begin
				out_q.solution    <= xm_rd_q;
				out_q.row_index   <= ROW_W'(i_q);
				out_q.last_result <= em_last;
				out_q.status      <= err_q;
			end
			ST_EM_HOLD: begin
				if (!out_stall && !em_last)
					i_q <= i_q + 1'b1;
			end
			default: x_q <= x_q;
		endcase
	end
endmodule

[sv/tridiagonal_thomas_solver_top.sv]
// Top level of the tridiagonal (Thomas) solver: front queue, back engine, dividers.
//
//  port group          dir   beat contents
//  in_valid/in_stall   in    one matrix row (in_beat_t)
//  out_valid/out_stall out   one solution component (out_beat_t)
//  cfg_we/cfg_wdata    in    symmetric mode bit
//
// The two 48-step dividers dominate a row's time in the back end. A last row
// then runs back substitution in BS_RD, BS_MUL and BS_SUB per stored row
// and emits each result via EM_RD, EM_LD and EM_HOLD, held by output stall.
// arst_n clears control state at once; the row stores need no clearing.
// The front queue holds two rows and takes beats while a result waits, until full.
`timescale 1ns / 1ps
module tridiagonal_thomas_solver_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  tts_pkg::in_beat_t  in_beat,
	output logic               out_valid,
	input  logic               out_stall,
	output tts_pkg::out_beat_t out_beat
);
	import tts_pkg::*;

	logic               sym_q;
	logic               job_valid;
	job_t               job;
	logic               job_pop;
	logic               div_start;
	logic signed [31:0] div_num_a;
	logic signed [31:0] div_num_b;
	logic signed [31:0] div_den;
	logic               done_a;
	logic               done_b;
	logic signed [31:0] quot_a;
	logic signed [31:0] quot_b;

	// Hold the mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sym_q <= 1'b0;
		else if (cfg_we)
			sym_q <= cfg_wdata;
	end

	tts_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_beat   (in_beat),
		.job_valid (job_valid),
		.job       (job),
		.job_pop   (job_pop)
	);

	tts_div u_div_a (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num_a),
		.den    (div_den),
		.done   (done_a),
		.quot   (quot_a)
	);

	tts_div u_div_b (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num_b),
		.den    (div_den),
		.done   (done_b),
		.quot   (quot_b)
	);

	tts_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.sym_mode   (sym_q),
		.job_valid  (job_valid),
		.job        (job),
		.job_pop    (job_pop),
		.div_start  (div_start),
		.div_num_a  (div_num_a),
		.div_num_b  (div_num_b),
		.div_den    (div_den),
		.div_done   (done_b),
		.div_quot_a (quot_a),
		.div_quot_b (quot_b),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_beat   (out_beat)
	);

	// The back end pops only a present job
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> job_valid) else $error("job popped from empty queue");

	// Both dividers run in lockstep
	a_div_lock: assert property (@(posedge clk) disable iff (!arst_n)
		done_a == done_b) else $error("dividers out of step");

	// Status is one of the defined codes
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_beat.status == STAT_OK || out_beat.status == STAT_ZERO
			|| out_beat.status == STAT_OVER)) else $error("undefined status");

	// The final result of a run ends the output burst
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && out_beat.last_result |=> !out_valid)
		else $error("result after end of run");
endmodule
